// ===== design/huffman_tree_walk_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman tree-walk decoder
// Concurrent checks on aclk with synchronous active-low reset aresetn.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_WALK_DECODER_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Property that holds at every clock edge outside reset.
`define HTWD_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define HTWD_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HTWD_CHECK(lbl, prop, msg)
`define HTWD_CHECK_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/htwd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwd_pkg
// Types, codes and constants of the Huffman tree-walk decoder.
// ----------------------------------------------------------------------------
package htwd_pkg;

    localparam int IDX_W          = 9;
    localparam int SYM_W          = 8;
    localparam int STATUS_W       = 2;
    localparam int FUNC_W         = 2;
    localparam int NODE_COUNT_DEF = 512;
    localparam int S_DATA_W       = 40;
    localparam int M_DATA_W       = 16;

    // item kinds on s_tuser
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BIT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_END  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS_LEFT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS_RIGHT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd3;

    // one node table entry, 28 bits
    typedef struct packed {
        logic             has_left;
        logic             has_right;
        logic [IDX_W-1:0] left_child;
        logic [IDX_W-1:0] right_child;
        logic [SYM_W-1:0] symbol;
    } node_t;

    // s_tdata layout, last field in the low bits
    typedef struct packed {
        logic [1:0]       pad;
        logic             code_bit;
        logic [SYM_W-1:0] leaf_symbol;
        logic [IDX_W-1:0] right_child;
        logic [IDX_W-1:0] left_child;
        logic             has_right;
        logic             has_left;
        logic [IDX_W-1:0] node_index;
    } in_t;

    typedef struct packed {
        logic                symbol_valid;
        logic [SYM_W-1:0]    symbol;
        logic [STATUS_W-1:0] status;
        logic                stream_done;
    } result_t;

endpackage

// ===== design/huffman_tree_walk_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Walks a Huffman code tree held in a synchronous node memory, one code bit
// per item, and emits one result per item through a two-entry output buffer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_*       in         tuser: func; tdata: node fields and code bit
//  m_*       out        tuser: symbol_valid; tdata: symbol, status; tlast: done
//  cfg_*     in         root_node, write only
//
//  A code bit with a present child reads the child entry from the node
//  memory while s_tready is low, and its leaf test runs on the registered read data.
//  Load, end-of-stream and missing-child items push their result on acceptance.
//  After reset and after each root_node write the root entry is fetched into
//  a local copy, and s_tready stays low until that copy is in place.
//  The output buffer keeps taking items while up to one result waits on m_*.
// ----------------------------------------------------------------------------
`include "huffman_tree_walk_decoder_macros.svh"

module huffman_tree_walk_decoder #(
    parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [htwd_pkg::IDX_W-1:0]      cfg_wr_data,   // root_node
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // node_index[8:0], has_left[9], has_right[10], left_child[19:11],
    // right_child[28:20], leaf_symbol[36:29], code_bit[37], zero[39:38]
    input  logic [htwd_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [htwd_pkg::FUNC_W-1:0]     s_tuser,       // func
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // symbol[7:0], status[9:8], zero[15:10]
    output logic [htwd_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tuser,       // symbol_valid
    output logic                            m_tlast        // stream_done
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    function automatic logic idx_ok(input logic [htwd_pkg::IDX_W-1:0] i);
        return 32'(i) < 32'(NODE_COUNT);
    endfunction

    // node memory
    htwd_pkg::node_t mem [NODE_COUNT];
    htwd_pkg::node_t rd_data_reg;
    logic            rd_oob_reg, rd_oob_next;
    logic            rd_req;
    logic [htwd_pkg::IDX_W-1:0] rd_idx;
    logic            mem_we;

    // walk state
    logic                        mid_reg, mid_next;
    logic [htwd_pkg::IDX_W-1:0]  walk_reg, walk_next;
    htwd_pkg::node_t             cur_reg, cur_next;
    logic [htwd_pkg::IDX_W-1:0]  root_reg, root_next;
    htwd_pkg::node_t             root_cache_reg, root_cache_next;
    logic                        root_valid_reg, root_valid_next;
    logic                        rootf_reg, rootf_next;
    logic                        pend_reg, pend_next;
    logic [htwd_pkg::IDX_W-1:0]  pend_idx_reg, pend_idx_next;

    // output buffer
    htwd_pkg::result_t head_reg, head_next, tail_reg, tail_next, push_res;
    logic              head_v_reg, head_v_next, tail_v_reg, tail_v_next;
    logic              push, pop;

    htwd_pkg::in_t     in_item;
    htwd_pkg::node_t   cur, nx, load_entry;
    logic              acc, br_has, nx_leaf;
    logic [htwd_pkg::IDX_W-1:0] br_child;

    assign in_item  = htwd_pkg::in_t'(s_tdata);
    assign s_tready = root_valid_reg && !pend_reg && !rootf_reg && !tail_v_reg;
    assign acc      = s_tvalid && s_tready;

    assign cur      = mid_reg ? cur_reg : root_cache_reg;
    assign br_has   = in_item.code_bit ? cur.has_right : cur.has_left;
    assign br_child = in_item.code_bit ? cur.right_child : cur.left_child;
    assign nx       = rd_oob_reg ? htwd_pkg::node_t'('0) : rd_data_reg;
    assign nx_leaf  = !nx.has_left && !nx.has_right;

    always_comb begin
        load_entry.has_left    = in_item.has_left;
        load_entry.has_right   = in_item.has_right;
        load_entry.left_child  = in_item.left_child;
        load_entry.right_child = in_item.right_child;
        load_entry.symbol      = in_item.leaf_symbol;
    end

    always_comb begin
        mid_next        = mid_reg;
        walk_next       = walk_reg;
        cur_next        = cur_reg;
        root_next       = root_reg;
        root_cache_next = root_cache_reg;
        root_valid_next = root_valid_reg;
        rootf_next      = 1'b0;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        push            = 1'b0;
        push_res        = '0;
        mem_we          = 1'b0;
        rd_req          = 1'b0;
        rd_idx          = root_reg;

        // finish a child fetch: leaf test on the fetched entry
        if (pend_reg) begin
            push = 1'b1;
            if (nx_leaf) begin
                push_res.symbol_valid = 1'b1;
                push_res.symbol       = nx.symbol;
                mid_next              = 1'b0;
            end else begin
                walk_next = pend_idx_reg;
                cur_next  = nx;
                mid_next  = (pend_idx_reg != root_reg);
            end
        end

        if (rootf_reg) begin
            root_cache_next = nx;
            root_valid_next = 1'b1;
        end

        if (acc) begin
            case (s_tuser)
                htwd_pkg::FUNC_LOAD: begin
                    push = 1'b1;
                    if (idx_ok(in_item.node_index)) begin
                        mem_we = 1'b1;
                        // keep local copies coherent with the table
                        if (mid_reg && walk_reg == in_item.node_index) begin
                            cur_next = load_entry;
                        end
                        if (root_reg == in_item.node_index) begin
                            root_cache_next = load_entry;
                        end
                    end
                end
                htwd_pkg::FUNC_BIT: begin
                    if (br_has) begin
                        rd_req        = 1'b1;
                        rd_idx        = br_child;
                        pend_next     = 1'b1;
                        pend_idx_next = br_child;
                    end else begin
                        push            = 1'b1;
                        push_res.status = in_item.code_bit ? htwd_pkg::ST_MISS_RIGHT
                                                           : htwd_pkg::ST_MISS_LEFT;
                        mid_next        = 1'b0;
                    end
                end
                htwd_pkg::FUNC_END: begin
                    push                 = 1'b1;
                    push_res.stream_done = 1'b1;
                    push_res.status      = mid_reg ? htwd_pkg::ST_INCOMPLETE
                                                   : htwd_pkg::ST_OK;
                    mid_next             = 1'b0;
                end
                default: begin
                    push = 1'b1;
                end
            endcase
        end else if (!root_valid_reg && !rootf_reg && !pend_reg && !cfg_wr_en) begin
            // refresh the root copy
            rd_req     = 1'b1;
            rd_idx     = root_reg;
            rootf_next = 1'b1;
        end

        if (cfg_wr_en) begin
            root_next       = cfg_wr_data;
            root_valid_next = 1'b0;
            rootf_next      = 1'b0;
        end
    end

    assign rd_oob_next = !idx_ok(rd_idx);

    // output buffer: head drives m_*, tail catches one more
    assign pop = head_v_reg && m_tready;

    always_comb begin
        head_next   = head_reg;
        head_v_next = head_v_reg;
        tail_next   = tail_reg;
        tail_v_next = tail_v_reg;
        if (pop) begin
            if (tail_v_reg) begin
                head_next   = tail_reg;
                tail_v_next = 1'b0;
            end else begin
                head_v_next = 1'b0;
            end
        end
        if (push) begin
            if (!head_v_next) begin
                head_next   = push_res;
                head_v_next = 1'b1;
            end else begin
                tail_next   = push_res;
                tail_v_next = 1'b1;
            end
        end
    end

    assign m_tvalid = head_v_reg;
    assign m_tdata  = {{(htwd_pkg::M_DATA_W - htwd_pkg::SYM_W - htwd_pkg::STATUS_W){1'b0}},
                       head_reg.status, head_reg.symbol};
    assign m_tuser  = head_reg.symbol_valid;
    assign m_tlast  = head_reg.stream_done;

    // node memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[AW'(in_item.node_index)] <= load_entry;
        end
        if (rd_req && idx_ok(rd_idx)) begin
            rd_data_reg <= mem[AW'(rd_idx)];
        end
        if (rd_req) begin
            rd_oob_reg <= rd_oob_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg        <= 1'b0;
            walk_reg       <= '0;
            root_reg       <= '0;
            root_valid_reg <= 1'b0;
            rootf_reg      <= 1'b0;
            pend_reg       <= 1'b0;
            head_v_reg     <= 1'b0;
            tail_v_reg     <= 1'b0;
        end else begin
            mid_reg        <= mid_next;
            walk_reg       <= walk_next;
            root_reg       <= root_next;
            root_valid_reg <= root_valid_next;
            rootf_reg      <= rootf_next;
            pend_reg       <= pend_next;
            head_v_reg     <= head_v_next;
            tail_v_reg     <= tail_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        root_cache_reg <= root_cache_next;
        pend_idx_reg   <= pend_idx_next;
        head_reg       <= head_next;
        tail_reg       <= tail_next;
    end

    `HTWD_CHECK(a_one_read_owner, !(pend_reg && rootf_reg), "child and root fetch overlap")
    `HTWD_CHECK(a_buf_order, !tail_v_reg || head_v_reg, "tail item without head item")
    `HTWD_CHECK_NEXT(a_fetch_one_cycle, pend_reg, !pend_reg, "child fetch held too long")
    `HTWD_CHECK_NEXT(a_bit_fetch, acc && s_tuser == htwd_pkg::FUNC_BIT && br_has, pend_reg, "child fetch not started")

endmodule

// ===== tb/htwd_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htwd_result_checker
// Watches the item, result and root_node write ports of the tree-walk decoder.
// Keeps its own node table and walk state, predicts one result per accepted
// item and compares every delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module htwd_result_checker
    import htwd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [IDX_W-1:0]      cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic [FUNC_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    output int                    mismatch_count,
    output int                    results_pending
);

    node_t            node_mem [NODE_COUNT_DEF];
    logic [IDX_W-1:0] root_idx;
    logic [IDX_W-1:0] walk_idx;
    logic             in_code;
    result_t          decode_q [$];

    // advance the walk by one item and return the result it causes
    function automatic result_t decode_step(input logic [FUNC_W-1:0] fn, input in_t d);
        result_t          r;
        node_t            here;
        node_t            nxt;
        logic [IDX_W-1:0] child;
        r = '0;
        case (fn)
            FUNC_LOAD: begin
                node_mem[d.node_index] = {d.has_left, d.has_right, d.left_child,
                                          d.right_child, d.leaf_symbol};
            end
            FUNC_BIT: begin
                here = node_mem[in_code ? walk_idx : root_idx];
                if (!d.code_bit && !here.has_left) begin
                    in_code  = 1'b0;
                    r.status = ST_MISS_LEFT;
                end else if (d.code_bit && !here.has_right) begin
                    in_code  = 1'b0;
                    r.status = ST_MISS_RIGHT;
                end else begin
                    child = d.code_bit ? here.right_child : here.left_child;
                    nxt   = node_mem[child];
                    if (!nxt.has_left && !nxt.has_right) begin
                        in_code        = 1'b0;
                        r.symbol_valid = 1'b1;
                        r.symbol       = nxt.symbol;
                    end else begin
                        // a step onto the root itself ends the code
                        walk_idx = child;
                        in_code  = (child != root_idx);
                    end
                end
            end
            FUNC_END: begin
                r.stream_done = 1'b1;
                if (in_code)
                    r.status = ST_INCOMPLETE;
                in_code = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input result_t want, input result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t %s: want valid=%0d sym=%02h status=%0d done=%0d,",
                      " got valid=%0d sym=%02h status=%0d done=%0d"},
                     $time, what, want.symbol_valid, want.symbol, want.status,
                     want.stream_done, got.symbol_valid, got.symbol, got.status,
                     got.stream_done);
    endtask

    initial begin
        mismatch_count  = 0;
        results_pending = 0;
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            foreach (node_mem[i])
                node_mem[i] = '0;
            root_idx = '0;
            walk_idx = '0;
            in_code  = 1'b0;
            decode_q.delete();
        end else begin
            if (cfg_wr_en)
                root_idx = cfg_wr_data;
            if (s_tvalid && s_tready)
                decode_q = {decode_q, decode_step(s_tuser, in_t'(s_tdata))};
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[SYM_W-1:0], m_tdata[SYM_W+STATUS_W-1:SYM_W], m_tlast};
                if (decode_q.size() == 0) begin
                    report_mismatch("result with no item outstanding", '0, got);
                end else begin
                    want = decode_q.pop_front();
                    if (got !== want)
                        report_mismatch("result mismatch", want, got);
                end
            end
        end
        results_pending = decode_q.size();
    end

endmodule

// ===== tb/tb_huffman_tree_walk_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_walk_decoder
// Loads code trees into the decoder node table, moves the root between them
// and streams code bits, end markers and stray items with random gaps on both
// sides. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_huffman_tree_walk_decoder;
    import htwd_pkg::*;

    localparam int                RANDOM_ITEMS = 700;
    localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [IDX_W-1:0]      cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [FUNC_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    int                    mismatch_count;
    int                    results_pending;

    // shadow of what has been loaded, so that no walk reaches an unwritten entry
    node_t                 tree_copy [NODE_COUNT_DEF];
    bit                    loaded    [NODE_COUNT_DEF];
    int                    loaded_list [$];
    bit                    tree_slot [NODE_COUNT_DEF];
    int                    inner_nodes [$];
    int                    send_calm;
    int                    recv_calm;
    int                    items_sent;

    huffman_tree_walk_decoder u_dut (.*);

    htwd_result_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // cycles to wait before the next item; calm stretches have no waits at all
    function automatic int pick_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            calm_left = int'($urandom_range(10, 40));
        return int'($urandom_range(0, 15));
    endfunction

    function automatic in_t noise_item();
        logic [63:0] r;
        in_t         d;
        r = {$urandom, $urandom};
        d = r[S_DATA_W-1:0];
        d.pad = '0;
        return d;
    endfunction

    function automatic node_t random_node();
        node_t n;
        n.has_left    = 1'($urandom_range(0, 1));
        n.has_right   = 1'($urandom_range(0, 1));
        n.left_child  = IDX_W'($urandom_range(0, NODE_COUNT_DEF - 1));
        n.right_child = IDX_W'($urandom_range(0, NODE_COUNT_DEF - 1));
        n.symbol      = SYM_W'($urandom_range(0, 255));
        return n;
    endfunction

    // any node whose present children are already loaded
    function automatic node_t random_linked_node();
        node_t n;
        n = random_node();
        if (n.has_left)
            n.left_child = IDX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
        if (n.has_right)
            n.right_child = IDX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
        return n;
    endfunction

    function automatic int fresh_slot();
        int p;
        do
            p = int'($urandom_range(0, NODE_COUNT_DEF - 1));
        while (tree_slot[p]);
        tree_slot[p] = 1'b1;
        return p;
    endfunction

    task automatic send_item(input logic [FUNC_W-1:0] fn, input in_t d);
        int gap;
        gap = pick_gap(send_calm);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (fn != FUNC_NONE)
            items_sent++;
    endtask

    task automatic send_plain(input logic [FUNC_W-1:0] fn);
        send_item(fn, noise_item());
    endtask

    task automatic send_bit(input logic b);
        in_t d;
        d = noise_item();
        d.code_bit = b;
        send_item(FUNC_BIT, d);
    endtask

    task automatic load_node(input int idx, input node_t n);
        in_t d;
        d = noise_item();
        d.node_index  = IDX_W'(idx);
        d.has_left    = n.has_left;
        d.has_right   = n.has_right;
        d.left_child  = n.left_child;
        d.right_child = n.right_child;
        d.leaf_symbol = n.symbol;
        send_item(FUNC_LOAD, d);
        tree_copy[idx] = n;
        if (!loaded[idx]) begin
            loaded[idx] = 1'b1;
            loaded_list = {loaded_list, idx};
        end
    endtask

    // drain the decoder, then write root_node
    task automatic write_root(input logic [IDX_W-1:0] idx);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= idx;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // load a random tree bottom up, children always before their parent
    task automatic build_tree(output logic [IDX_W-1:0] tree_root);
        int    pool [$];
        int    n_leaves;
        int    a;
        int    b;
        int    k;
        int    p;
        node_t n;
        foreach (tree_slot[i])
            tree_slot[i] = 1'b0;
        inner_nodes.delete();
        n_leaves = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
        repeat (n_leaves) begin
            n = random_node();
            n.has_left  = 1'b0;
            n.has_right = 1'b0;
            p = fresh_slot();
            load_node(p, n);
            pool = {pool, p};
        end
        while (pool.size() > 1 || inner_nodes.size() == 0) begin
            k = $urandom_range(0, pool.size() - 1);
            a = pool[k];
            pool.delete(k);
            n = random_node();
            if (pool.size() > 0 && $urandom_range(0, 4) != 0) begin
                k = $urandom_range(0, pool.size() - 1);
                b = pool[k];
                pool.delete(k);
                n.has_left    = 1'b1;
                n.has_right   = 1'b1;
                n.left_child  = IDX_W'(a);
                n.right_child = IDX_W'(b);
            end else if ($urandom_range(0, 1)) begin
                n.has_left   = 1'b1;
                n.has_right  = 1'b0;
                n.left_child = IDX_W'(a);
            end else begin
                n.has_left    = 1'b0;
                n.has_right   = 1'b1;
                n.right_child = IDX_W'(a);
            end
            p = fresh_slot();
            load_node(p, n);
            pool        = {pool, p};
            inner_nodes = {inner_nodes, p};
        end
        tree_root = IDX_W'(pool[0]);
        // point one inner node back at the root now and then
        if (inner_nodes.size() > 1 && $urandom_range(0, 2) == 0) begin
            p = inner_nodes[$urandom_range(0, inner_nodes.size() - 2)];
            n = tree_copy[p];
            if ($urandom_range(0, 1)) begin
                n.has_left   = 1'b1;
                n.left_child = tree_root;
            end else begin
                n.has_right   = 1'b1;
                n.right_child = tree_root;
            end
            load_node(p, n);
        end
    endtask

    // result side: random stalls, two long hold-offs to back up the input
    initial begin : result_sink
        int   gap;
        int   hold;
        int   taken;
        logic took;
        m_tready  = 1'b0;
        recv_calm = 0;
        gap       = 0;
        hold      = 0;
        taken     = 0;
        forever begin
            @(posedge aclk);
            took = m_tvalid && m_tready;
            @(negedge aclk);
            if (took) begin
                taken++;
                gap = pick_gap(recv_calm);
                if (taken % 400 == 200)
                    hold = 300;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (gap > 0) begin
                m_tready <= 1'b0;
                gap--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [IDX_W-1:0] tr;
        int               k;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_LOAD;
        send_calm   = 0;
        items_sent  = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // end of stream and a stray item with nothing loaded yet
        send_plain(FUNC_END);
        send_plain(FUNC_NONE);
        load_node(511, {1'b0, 1'b0, 9'h1FF, 9'h1FF, 8'hFF});
        load_node(0, {1'b1, 1'b0, 9'd511, 9'd0, 8'h00});
        send_bit(1'b0);
        send_bit(1'b1);
        load_node(5, {1'b0, 1'b0, 9'h000, 9'h0AA, 8'h5A});
        load_node(3, {1'b1, 1'b1, 9'd511, 9'd0, 8'h77});
        load_node(0, {1'b1, 1'b1, 9'd3, 9'd5, 8'h00});
        send_bit(1'b1);
        // step back onto the root, then end with the walk at rest
        send_bit(1'b0);
        send_bit(1'b1);
        send_plain(FUNC_END);
        send_bit(1'b0);
        send_plain(FUNC_END);
        send_bit(1'b0);
        send_bit(1'b0);
        load_node(6, {1'b0, 1'b1, 9'h155, 9'd5, 8'h11});
        write_root(9'd6);
        send_bit(1'b0);
        send_bit(1'b1);
        // move the root while a code is open
        write_root(9'd0);
        send_bit(1'b0);
        write_root(9'd511);
        send_bit(1'b1);
        send_bit(1'b1);
        send_bit(1'b0);
        send_plain(FUNC_END);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            build_tree(tr);
            write_root(tr);
            repeat ($urandom_range(20, 60)) begin
                k = int'($urandom_range(0, 99));
                if (k < 82)
                    send_bit(1'($urandom_range(0, 1)));
                else if (k < 88)
                    send_plain(FUNC_END);
                else if (k < 96)
                    load_node(int'($urandom_range(0, NODE_COUNT_DEF - 1)),
                              random_linked_node());
                else
                    send_plain(FUNC_NONE);
            end
            // leave the code open half the time so the next root write lands mid-code
            if ($urandom_range(0, 1))
                send_plain(FUNC_END);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
